// File: rtl/core/cr3_pkg.sv
// ----------------------------------------------------------------------------
// cr3_pkg
// Shared constants, types and arithmetic helpers of the three-body
// acceleration and potential Hessian pipeline.
// ----------------------------------------------------------------------------
package cr3_pkg;

	localparam int FRAC_BITS = 28;
	localparam int MU_W      = 28;
	localparam int IN_W      = 32;
	localparam int OUT_W     = 48;
	localparam int N_TERM    = 9;
	localparam int EXP_W     = 10;
	localparam int STEPS     = 4;
	localparam int SQ_STG    = 32 / STEPS;
	localparam int RC_STG    = 32 / STEPS;
	localparam int PRI_LAT   = 9 + SQ_STG + RC_STG;

	localparam logic [MU_W-1:0]     MU_RESET = 28'd3261647;
	localparam logic [28:0]         ONE_MASS = 29'(1) << FRAC_BITS;
	localparam logic signed [33:0]  ONE_POS  = 34'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0]  ONE_OUT  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0]  OUT_MAX  = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
	localparam logic signed [63:0]  OUT_MIN  = -(64'sd1 <<< (OUT_W - 1));

	typedef logic signed [EXP_W-1:0] expo_t;

	typedef struct packed {
		logic [31:0] m;
		logic [6:0]  lz;
	} nrm_t;

	typedef struct packed {
		logic [31:0] m;
		logic        hi;
	} pnrm_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_t;

	typedef struct packed {
		logic [31:0] den;
		expo_t       e;
		logic [33:0] rem;
		logic [31:0] quo;
	} rc_t;

	typedef struct packed {
		logic [N_TERM-1:0][31:0]      mn_m;
		logic [N_TERM-1:0][EXP_W-1:0] mn_e;
		logic [N_TERM-1:0]            tz;
		logic [N_TERM-1:0]            tneg;
		logic [2:0]                   k;
		logic [31:0]                  qm;
		expo_t                        eq;
		expo_t                        ed;
		logic                         zero;
	} ppl_t;

	typedef struct packed {
		logic [N_TERM-1:0][61:0] term;
		logic                    zero;
		logic                    sat;
	} pout_t;

	typedef struct packed {
		logic [OUT_W-1:0] v;
		logic             sat;
	} clip_t;

	function automatic nrm_t nrm64(input logic [63:0] w);
		nrm_t r;
		logic [63:0] sh;
		r.lz = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (w[i]) begin
				r.lz = 7'(63 - i);
			end
		end
		sh = w << r.lz;
		r.m = sh[63:32];
		return r;
	endfunction

	function automatic pnrm_t pnorm(input logic [63:0] p);
		pnrm_t r;
		r.hi = p[63];
		r.m = p[63] ? p[63:32] : p[62:31];
		return r;
	endfunction

	function automatic sq_t sq_step(input sq_t s_in);
		sq_t s;
		logic [35:0] r;
		logic [35:0] tr;
		s = s_in;
		for (int i = 0; i < STEPS; i++) begin
			r = {s.rem[33:0], s.rad[63:62]};
			tr = {2'b00, s.root, 2'b01};
			s.rad = {s.rad[61:0], 2'b00};
			if (r >= tr) begin
				s.rem = r - tr;
				s.root = {s.root[30:0], 1'b1};
			end else begin
				s.rem = r;
				s.root = {s.root[30:0], 1'b0};
			end
		end
		return s;
	endfunction

	function automatic rc_t rc_step(input rc_t c_in);
		rc_t c;
		logic [33:0] r;
		c = c_in;
		for (int i = 0; i < STEPS; i++) begin
			r = {c.rem[32:0], 1'b0};
			if (r >= {2'b00, c.den}) begin
				c.rem = r - {2'b00, c.den};
				c.quo = {c.quo[30:0], 1'b1};
			end else begin
				c.rem = r;
				c.quo = {c.quo[30:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic clip_t clip48(input logic signed [63:0] v);
		clip_t r;
		if (v > OUT_MAX) begin
			r.v = OUT_MAX[OUT_W-1:0];
			r.sat = 1'b1;
		end else if (v < OUT_MIN) begin
			r.v = OUT_MIN[OUT_W-1:0];
			r.sat = 1'b1;
		end else begin
			r.v = v[OUT_W-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/cr3_sqrt.sv
// ----------------------------------------------------------------------------
// cr3_sqrt
// Pipelined integer square root of a normalized 64-bit radicand, a few
// result bits per stage.
// ----------------------------------------------------------------------------
module cr3_sqrt (
	input  logic          clk,
	input  logic          en,
	input  logic [63:0]   rad,
	input  cr3_pkg::ppl_t pl_in,
	output logic [31:0]   root,
	output cr3_pkg::ppl_t pl_out
);

	cr3_pkg::sq_t  st_s [cr3_pkg::SQ_STG];
	cr3_pkg::ppl_t pl_s [cr3_pkg::SQ_STG];
	cr3_pkg::sq_t  st_in;

	assign st_in = '{rem: '0, root: '0, rad: rad};

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= cr3_pkg::sq_step(st_in);
			pl_s[0] <= pl_in;
			for (int i = 1; i < cr3_pkg::SQ_STG; i++) begin
				st_s[i] <= cr3_pkg::sq_step(st_s[i-1]);
				pl_s[i] <= pl_s[i-1];
			end
		end
	end

	assign root = st_s[cr3_pkg::SQ_STG-1].root;
	assign pl_out = pl_s[cr3_pkg::SQ_STG-1];

endmodule

// File: rtl/core/cr3_recip.sv
// ----------------------------------------------------------------------------
// cr3_recip
// Two pipelined reciprocals 2^63 / mantissa, computed by restoring division,
// with the exponent of each result.
// ----------------------------------------------------------------------------
module cr3_recip (
	input  logic                     clk,
	input  logic                     en,
	input  logic [1:0][31:0]         den,
	input  logic [1:0][9:0]          den_e,
	input  cr3_pkg::ppl_t            pl_in,
	output logic [1:0][31:0]         inv_m,
	output logic [1:0][9:0]          inv_e,
	output cr3_pkg::ppl_t            pl_out
);

	cr3_pkg::rc_t  st_s [cr3_pkg::RC_STG][2];
	cr3_pkg::ppl_t pl_s [cr3_pkg::RC_STG];
	cr3_pkg::rc_t  st_in [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			st_in[j].den = den[j];
			st_in[j].e = -10'sd63 - $signed(den_e[j]);
			st_in[j].rem = 34'h0_8000_0000;
			st_in[j].quo = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s[0] <= pl_in;
			for (int j = 0; j < 2; j++) begin
				st_s[0][j] <= cr3_pkg::rc_step(st_in[j]);
			end
			for (int i = 1; i < cr3_pkg::RC_STG; i++) begin
				pl_s[i] <= pl_s[i-1];
				for (int j = 0; j < 2; j++) begin
					st_s[i][j] <= cr3_pkg::rc_step(st_s[i-1][j]);
				end
			end
		end
	end

	// A mantissa of exactly one half gives a quotient of 2^32, renormalized here.
	always_comb begin
		for (int j = 0; j < 2; j++) begin
			if (st_s[cr3_pkg::RC_STG-1][j].den == 32'h8000_0000) begin
				inv_m[j] = 32'h8000_0000;
				inv_e[j] = st_s[cr3_pkg::RC_STG-1][j].e + 10'sd1;
			end else begin
				inv_m[j] = st_s[cr3_pkg::RC_STG-1][j].quo;
				inv_e[j] = st_s[cr3_pkg::RC_STG-1][j].e;
			end
		end
	end

	assign pl_out = pl_s[cr3_pkg::RC_STG-1];

endmodule

// File: rtl/core/cr3_primary.sv
// ----------------------------------------------------------------------------
// cr3_primary
// Contribution of one primary: offsets, distance, inverse powers of the
// distance and the nine scaled terms, as a fixed-latency pipeline.
// ----------------------------------------------------------------------------
module cr3_primary (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] dx,
	input  logic signed [31:0] dy,
	input  logic signed [31:0] dz,
	input  logic [28:0]        mass,
	output cr3_pkg::pout_t     res
);

	// Stage 1: magnitudes, range reduction.
	logic [33:0] mgx, mgy, mgz, mx;
	logic [2:0]  k1;
	logic [29:0] ma, mb, mc;
	logic signed [30:0] a_s1, b_s1, c_s1;
	logic [2:0]  k_s1;
	logic [28:0] mass_s1;
	logic        zero_s1;

	always_comb begin
		mgx = dx[33] ? 34'(-dx) : 34'(dx);
		mgy = {2'b00, (dy[31] ? 32'(-dy) : 32'(dy))};
		mgz = {2'b00, (dz[31] ? 32'(-dz) : 32'(dz))};
		mx = mgx;
		if (mgy > mx) begin
			mx = mgy;
		end
		if (mgz > mx) begin
			mx = mgz;
		end
		if (mx[33]) begin
			k1 = 3'd4;
		end else if (mx[32]) begin
			k1 = 3'd3;
		end else if (mx[31]) begin
			k1 = 3'd2;
		end else if (mx[30]) begin
			k1 = 3'd1;
		end else begin
			k1 = 3'd0;
		end
		ma = 30'(mgx >> k1);
		mb = 30'(mgy >> k1);
		mc = 30'(mgz >> k1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= dx[33] ? -$signed({1'b0, ma}) : $signed({1'b0, ma});
			b_s1 <= dy[31] ? -$signed({1'b0, mb}) : $signed({1'b0, mb});
			c_s1 <= dz[31] ? -$signed({1'b0, mc}) : $signed({1'b0, mc});
			k_s1 <= k1;
			mass_s1 <= mass;
			zero_s1 <= (mx == '0);
		end
	end

	// Stage 2: squares and cross products.
	logic signed [61:0] aa_s2, bb_s2, cc_s2, ab_s2, ac_s2, bc_s2;
	logic signed [30:0] a_s2, b_s2, c_s2;
	logic [2:0]  k_s2;
	logic [28:0] mass_s2;
	logic        zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			aa_s2 <= a_s1 * a_s1;
			bb_s2 <= b_s1 * b_s1;
			cc_s2 <= c_s1 * c_s1;
			ab_s2 <= a_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
			bc_s2 <= b_s1 * c_s1;
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			c_s2 <= c_s1;
			k_s2 <= k_s1;
			mass_s2 <= mass_s1;
			zero_s2 <= zero_s1;
		end
	end

	// Stage 3: squared distance, numerators, mass normalization.
	logic signed [63:0] q3;
	logic signed [63:0] n3 [cr3_pkg::N_TERM];
	cr3_pkg::nrm_t      nm3;
	logic signed [63:0] n_s3 [cr3_pkg::N_TERM];
	logic [63:0]        q_s3;
	logic [31:0]        mass_m_s3;
	cr3_pkg::expo_t     mass_e_s3;
	logic               massz_s3;
	logic [2:0]         k_s3;
	logic               zero_s3;

	always_comb begin
		q3 = 64'(aa_s2) + 64'(bb_s2) + 64'(cc_s2);
		n3[0] = 64'(a_s2);
		n3[1] = 64'(b_s2);
		n3[2] = 64'(c_s2);
		n3[3] = (64'(aa_s2) <<< 1) + 64'(aa_s2) - q3;
		n3[4] = (64'(bb_s2) <<< 1) + 64'(bb_s2) - q3;
		n3[5] = (64'(cc_s2) <<< 1) + 64'(cc_s2) - q3;
		n3[6] = (64'(ab_s2) <<< 1) + 64'(ab_s2);
		n3[7] = (64'(ac_s2) <<< 1) + 64'(ac_s2);
		n3[8] = (64'(bc_s2) <<< 1) + 64'(bc_s2);
		nm3 = cr3_pkg::nrm64({mass_s2, 35'b0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
				n_s3[t] <= n3[t];
			end
			q_s3 <= q3;
			mass_m_s3 <= nm3.m;
			mass_e_s3 <= -10'sd3 - $signed({3'b000, nm3.lz});
			massz_s3 <= (mass_s2 == '0);
			k_s3 <= k_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Stage 4: normalize numerators and the squared distance.
	cr3_pkg::nrm_t nn4 [cr3_pkg::N_TERM];
	cr3_pkg::nrm_t nq4;
	logic [31:0]    n_m_s4 [cr3_pkg::N_TERM];
	cr3_pkg::expo_t n_e_s4 [cr3_pkg::N_TERM];
	logic [cr3_pkg::N_TERM-1:0] tz_s4, tneg_s4;
	logic [63:0]    qn_s4;
	logic [31:0]    qm_s4;
	cr3_pkg::expo_t eq_s4, ed_s4;
	logic [31:0]    mass_m_s4;
	cr3_pkg::expo_t mass_e_s4;
	logic [2:0]     k_s4;
	logic           zero_s4;

	always_comb begin
		for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
			nn4[t] = cr3_pkg::nrm64(n_s3[t][63] ? 64'(-n_s3[t]) : 64'(n_s3[t]));
		end
		nq4 = cr3_pkg::nrm64(q_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
				n_m_s4[t] <= nn4[t].m;
				n_e_s4[t] <= 10'sd32 - $signed({3'b000, nn4[t].lz});
				tz_s4[t] <= (n_s3[t] == '0) || massz_s3;
				tneg_s4[t] <= n_s3[t][63];
			end
			qn_s4 <= q_s3 << {nq4.lz[6:1], 1'b0};
			qm_s4 <= nq4.m;
			eq_s4 <= 10'sd32 - $signed({3'b000, nq4.lz});
			ed_s4 <= -$signed({4'b0000, nq4.lz[6:1]});
			mass_m_s4 <= mass_m_s3;
			mass_e_s4 <= mass_e_s3;
			k_s4 <= k_s3;
			zero_s4 <= zero_s3;
		end
	end

	// Stage 5: mass times numerator.
	cr3_pkg::pnrm_t mn5 [cr3_pkg::N_TERM];
	cr3_pkg::ppl_t  pl5;
	cr3_pkg::ppl_t  pl_s5;
	logic [63:0]    qn_s5;

	always_comb begin
		for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
			mn5[t] = cr3_pkg::pnorm(mass_m_s4 * n_m_s4[t]);
			pl5.mn_m[t] = mn5[t].m;
			pl5.mn_e[t] = mass_e_s4 + n_e_s4[t] + (mn5[t].hi ? 10'sd32 : 10'sd31);
		end
		pl5.tz = tz_s4;
		pl5.tneg = tneg_s4;
		pl5.k = k_s4;
		pl5.qm = qm_s4;
		pl5.eq = eq_s4;
		pl5.ed = ed_s4;
		pl5.zero = zero_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s5 <= pl5;
			qn_s5 <= qn_s4;
		end
	end

	// Distance by square root.
	logic [31:0]   root_sq;
	cr3_pkg::ppl_t pl_sq;

	cr3_sqrt u_sqrt (
		.clk    (clk),
		.en     (en),
		.rad    (qn_s5),
		.pl_in  (pl_s5),
		.root   (root_sq),
		.pl_out (pl_sq)
	);

	// Stage 14: q*d and q*q.
	cr3_pkg::pnrm_t qd14, qq14;
	logic [31:0]    root_s14, qd_m_s14, qq_m_s14;
	cr3_pkg::expo_t qd_e_s14, qq_e_s14;
	cr3_pkg::ppl_t  pl_s14;

	always_comb begin
		qd14 = cr3_pkg::pnorm(pl_sq.qm * root_sq);
		qq14 = cr3_pkg::pnorm(pl_sq.qm * pl_sq.qm);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_s14 <= root_sq;
			qd_m_s14 <= qd14.m;
			qd_e_s14 <= pl_sq.eq + pl_sq.ed + (qd14.hi ? 10'sd32 : 10'sd31);
			qq_m_s14 <= qq14.m;
			qq_e_s14 <= pl_sq.eq + pl_sq.eq + (qq14.hi ? 10'sd32 : 10'sd31);
			pl_s14 <= pl_sq;
		end
	end

	// Stage 15: q*q*d.
	cr3_pkg::pnrm_t   qqd15;
	logic [1:0][31:0] den_s15;
	logic [1:0][9:0]  den_e_s15;
	cr3_pkg::ppl_t    pl_s15;

	assign qqd15 = cr3_pkg::pnorm(qq_m_s14 * root_s14);

	always_ff @(posedge clk) begin
		if (en) begin
			den_s15[0] <= qd_m_s14;
			den_e_s15[0] <= qd_e_s14;
			den_s15[1] <= qqd15.m;
			den_e_s15[1] <= qq_e_s14 + pl_s14.ed + (qqd15.hi ? 10'sd32 : 10'sd31);
			pl_s15 <= pl_s14;
		end
	end

	// Inverse third and fifth powers of the distance.
	logic [1:0][31:0] inv_m;
	logic [1:0][9:0]  inv_e;
	cr3_pkg::ppl_t    pl_rc;

	cr3_recip u_recip (
		.clk    (clk),
		.en     (en),
		.den    (den_s15),
		.den_e  (den_e_s15),
		.pl_in  (pl_s15),
		.inv_m  (inv_m),
		.inv_e  (inv_e),
		.pl_out (pl_rc)
	);

	// Stage 24: scale each term by its inverse power.
	cr3_pkg::pnrm_t pr24 [cr3_pkg::N_TERM];
	cr3_pkg::expo_t ea24 [cr3_pkg::N_TERM];
	cr3_pkg::expo_t kk24;
	logic [31:0]    pm_s24 [cr3_pkg::N_TERM];
	cr3_pkg::expo_t pe_s24 [cr3_pkg::N_TERM];
	logic [cr3_pkg::N_TERM-1:0] tz_s24, tneg_s24;
	logic           zero_s24;

	always_comb begin
		kk24 = $signed({7'b0000000, pl_rc.k});
		for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
			if (t < 3) begin
				pr24[t] = cr3_pkg::pnorm(pl_rc.mn_m[t] * inv_m[0]);
				ea24[t] = $signed(pl_rc.mn_e[t]) + $signed(inv_e[0])
					+ 10'(2 * cr3_pkg::FRAC_BITS) - kk24 - kk24;
			end else begin
				pr24[t] = cr3_pkg::pnorm(pl_rc.mn_m[t] * inv_m[1]);
				ea24[t] = $signed(pl_rc.mn_e[t]) + $signed(inv_e[1])
					+ 10'(3 * cr3_pkg::FRAC_BITS) - kk24 - kk24 - kk24;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
				pm_s24[t] <= pr24[t].m;
				pe_s24[t] <= ea24[t] + (pr24[t].hi ? 10'sd32 : 10'sd31);
			end
			tz_s24 <= pl_rc.tz;
			tneg_s24 <= pl_rc.tneg;
			zero_s24 <= pl_rc.zero;
		end
	end

	// Stage 25: convert to fixed point with the term limit, apply the sign.
	logic [60:0] mag25 [cr3_pkg::N_TERM];
	logic [9:0]  npe25 [cr3_pkg::N_TERM];
	logic [cr3_pkg::N_TERM-1:0] sat25;
	logic [cr3_pkg::N_TERM-1:0][61:0] term_s25;
	logic        zero_s25;
	logic        sat_s25;

	always_comb begin
		for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
			npe25[t] = 10'(-pe_s24[t]);
			sat25[t] = 1'b0;
			if (tz_s24[t]) begin
				mag25[t] = '0;
			end else if (pe_s24[t] >= 10'sd29) begin
				mag25[t] = 61'(1) << 60;
				sat25[t] = 1'b1;
			end else if (pe_s24[t] >= 10'sd0) begin
				mag25[t] = {29'b0, pm_s24[t]} << pe_s24[t][4:0];
			end else if (pe_s24[t] < -10'sd31) begin
				mag25[t] = '0;
			end else begin
				mag25[t] = {29'b0, pm_s24[t] >> npe25[t][4:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < cr3_pkg::N_TERM; t++) begin
				term_s25[t] <= tneg_s24[t] ? 62'(-{1'b0, mag25[t]}) : {1'b0, mag25[t]};
			end
			zero_s25 <= zero_s24;
			sat_s25 <= |sat25;
		end
	end

	assign res = '{term: term_s25, zero: zero_s25, sat: sat_s25};

endmodule

// File: rtl/core/cr3bp_accel_and_potential_hessian.sv
// ----------------------------------------------------------------------------
// cr3bp_accel_and_potential_hessian
// Accelerations and pseudo-potential Hessian of the circular restricted
// three-body problem for one rotating-frame state per transfer.
// ----------------------------------------------------------------------------
// Usage:
// A state (pos_x, pos_y, pos_z, vel_x, vel_y, signed Q3.28) enters as one
// transfer on the s_t* channel. The result leaves as one transfer on the
// m_t* channel: accel_x/y/z and u_xx, u_yy, u_zz, u_xy, u_xz, u_yz in signed
// Q19.28, with the saturation flag in m_tuser, also set when the state lies on a primary.
// The mass ratio mu (unsigned Q0.28) is written through cfg_we/cfg_wdata; the
// user must write it only while the block holds no work, as the block itself
// does not enforce this. Reset loads the Earth-Moon value. One state is taken
// every cycle while the receiver does not stall; the two primaries are worked
// in parallel pipelines and the square root and reciprocals run as 8-stage
// units of 4 bits per stage. When the receiver stalls with a result waiting,
// the whole pipeline holds and s_tready falls; nothing is lost or repeated.
// Reset empties the pipeline and the output register.
// ----------------------------------------------------------------------------
module cr3bp_accel_and_potential_hessian (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y
	input  logic [159:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// accel_x, accel_y, accel_z, u_xx, u_yy, u_zz, u_xy, u_xz, u_yz
	output logic [431:0] m_tdata,
	// saturated, or the state lies on a primary
	output logic [0:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [27:0]  cfg_wdata
);

	logic [cr3_pkg::MU_W-1:0] mass_ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_ratio_q <= cr3_pkg::MU_RESET;
		end else if (cfg_we) begin
			mass_ratio_q <= cfg_wdata;
		end
	end

	logic en;
	logic accept;
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign accept = s_tvalid && en;

	logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y;
	assign pos_x = s_tdata[31:0];
	assign pos_y = s_tdata[63:32];
	assign pos_z = s_tdata[95:64];
	assign vel_x = s_tdata[127:96];
	assign vel_y = s_tdata[159:128];

	logic signed [33:0] dx1, dx2;
	logic [28:0]        mass1, mass2;
	assign dx1 = 34'(pos_x) + $signed({6'b000000, mass_ratio_q});
	assign dx2 = dx1 - cr3_pkg::ONE_POS;
	assign mass2 = {1'b0, mass_ratio_q};
	assign mass1 = cr3_pkg::ONE_MASS - mass2;

	cr3_pkg::pout_t r1, r2;

	cr3_primary u_pri1 (
		.clk  (clk),
		.en   (en),
		.dx   (dx1),
		.dy   (pos_y),
		.dz   (pos_z),
		.mass (mass1),
		.res  (r1)
	);

	cr3_primary u_pri2 (
		.clk  (clk),
		.en   (en),
		.dx   (dx2),
		.dy   (pos_y),
		.dz   (pos_z),
		.mass (mass2),
		.res  (r2)
	);

	logic               vld_s [cr3_pkg::PRI_LAT];
	logic signed [33:0] bax_s [cr3_pkg::PRI_LAT];
	logic signed [33:0] bay_s [cr3_pkg::PRI_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cr3_pkg::PRI_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= accept;
			for (int i = 1; i < cr3_pkg::PRI_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bax_s[0] <= 34'(pos_x) + (34'(vel_y) <<< 1);
			bay_s[0] <= 34'(pos_y) - (34'(vel_x) <<< 1);
			for (int i = 1; i < cr3_pkg::PRI_LAT; i++) begin
				bax_s[i] <= bax_s[i-1];
				bay_s[i] <= bay_s[i-1];
			end
		end
	end

	logic signed [63:0] t1 [cr3_pkg::N_TERM];
	logic signed [63:0] t2 [cr3_pkg::N_TERM];
	logic signed [63:0] sum [cr3_pkg::N_TERM];
	cr3_pkg::clip_t     clp [cr3_pkg::N_TERM];
	logic               any_clip;
	logic               zero;

	always_comb begin
		for (int i = 0; i < cr3_pkg::N_TERM; i++) begin
			t1[i] = 64'($signed(r1.term[i]));
			t2[i] = 64'($signed(r2.term[i]));
		end
		sum[0] = 64'(bax_s[cr3_pkg::PRI_LAT-1]) - t1[0] - t2[0];
		sum[1] = 64'(bay_s[cr3_pkg::PRI_LAT-1]) - t1[1] - t2[1];
		sum[2] = -t1[2] - t2[2];
		sum[3] = cr3_pkg::ONE_OUT + t1[3] + t2[3];
		sum[4] = cr3_pkg::ONE_OUT + t1[4] + t2[4];
		for (int i = 5; i < cr3_pkg::N_TERM; i++) begin
			sum[i] = t1[i] + t2[i];
		end
		any_clip = 1'b0;
		for (int i = 0; i < cr3_pkg::N_TERM; i++) begin
			clp[i] = cr3_pkg::clip48(sum[i]);
			any_clip = any_clip | clp[i].sat;
		end
		zero = r1.zero || r2.zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s[cr3_pkg::PRI_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < cr3_pkg::N_TERM; i++) begin
				m_tdata[cr3_pkg::OUT_W*i +: cr3_pkg::OUT_W] <= zero ? '0 : clp[i].v;
			end
			m_tuser[0] <= zero || r1.sat || r2.sat || any_clip;
		end
	end

	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s[0])
		else $error("accepted transfer did not enter the pipeline");

	a_stall_holds : assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> m_tvalid && $stable(vld_s[cr3_pkg::PRI_LAT-1]))
		else $error("pipeline moved while the output was stalled");

endmodule
